### rtl/rps_pkg.sv
`default_nettype none

package rps_pkg;

    localparam int ID_W    = 8;
    localparam int PRIO_W  = 8;
    localparam int BURST_W = 16;
    localparam int TIME_W  = 32;
    localparam int PEN_W   = 8;
    localparam int STATE_W = 2;

    localparam logic [STATE_W-1:0] CPU_IDLE   = 2'd0;
    localparam logic [STATE_W-1:0] CPU_SWITCH = 2'd1;
    localparam logic [STATE_W-1:0] CPU_RUN    = 2'd2;

    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 152;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_SWITCH = 3'b010,
        MODE_RUN    = 3'b100
    } t_mode;

    typedef struct packed {
        logic [TIME_W-1:0]  arr;
        logic [BURST_W-1:0] rem;
        logic [PRIO_W-1:0]  prio;
        logic [ID_W-1:0]    id;
    } t_entry;

    typedef struct packed {
        logic               command;
        logic [ID_W-1:0]    task_id;
        logic [PRIO_W-1:0]  priority_req;
        logic [BURST_W-1:0] burst;
    } t_item;

    // first member sits in the top bits
    typedef struct packed {
        logic [TIME_W-1:0]  switch_time_total;
        logic [TIME_W-1:0]  switch_count;
        logic [TIME_W-1:0]  now_time;
        logic [TIME_W-1:0]  turnaround;
        logic [ID_W-1:0]    finished_id;
        logic               finished;
        logic [ID_W-1:0]    running_id;
        logic [STATE_W-1:0] cpu_state;
        logic               dropped;
    } t_result;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

    function automatic logic [STATE_W-1:0] mode_code(input t_mode m);
        logic [STATE_W-1:0] c;
        case (m)
            MODE_SWITCH: c = CPU_SWITCH;
            MODE_RUN:    c = CPU_RUN;
            default:     c = CPU_IDLE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/rps_best_sel.sv
`default_nettype none

module rps_best_sel #(
    parameter int N    = 16,
    parameter int IDXW = 4
) (
    input  wire logic            i_valid [N],
    input  wire rps_pkg::t_entry i_table [N],
    output logic                 o_found,
    output logic [IDXW-1:0]      o_idx,
    output rps_pkg::t_entry      o_entry
);
    import rps_pkg::*;

    localparam int P     = 1 << IDXW;
    localparam int NODES = 2 * P - 1;

    logic            nv [NODES];
    logic [IDXW-1:0] ni [NODES];
    t_entry          ne [NODES];
    logic            pick_r [P-1];

    // leaves
    for (genvar i = 0; i < P; i++) begin : g_leaf
        if (i < N) begin : g_used
            assign nv[P-1+i] = i_valid[i];
            assign ni[P-1+i] = IDXW'(i);
            assign ne[P-1+i] = i_table[i];
        end else begin : g_pad
            assign nv[P-1+i] = 1'b0;
            assign ni[P-1+i] = '0;
            assign ne[P-1+i] = '0;
        end
    end

    // compare tree, left wins ties
    for (genvar k = 0; k < P - 1; k++) begin : g_node
        assign pick_r[k] = nv[2*k+2] &&
            (!nv[2*k+1] ||
             ({ne[2*k+2].prio, ne[2*k+2].id} < {ne[2*k+1].prio, ne[2*k+1].id}));
        assign nv[k] = nv[2*k+1] | nv[2*k+2];
        assign ni[k] = pick_r[k] ? ni[2*k+2] : ni[2*k+1];
        assign ne[k] = pick_r[k] ? ne[2*k+2] : ne[2*k+1];
    end

    assign o_found = nv[0];
    assign o_idx   = ni[0];
    assign o_entry = ne[0];

endmodule

`default_nettype wire

### rtl/rps_core.sv
`default_nettype none

module rps_core #(
    parameter int N    = 16,
    parameter int IDXW = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_fire,
    input  wire rps_pkg::t_item             i_item,
    input  wire logic                       i_cfg_we,
    input  wire logic [rps_pkg::PEN_W-1:0]  i_cfg_wdata,
    output rps_pkg::t_result                o_result
);
    import rps_pkg::*;

    t_entry            r_table [N];
    logic              r_valid [N];
    logic              n_valid [N];
    t_entry            r_run, n_run;
    t_mode             r_mode, n_mode;
    logic [PEN_W-1:0]  r_sl, n_sl;
    logic [TIME_W-1:0] r_time, n_time;
    logic [TIME_W-1:0] r_tally, n_tally;
    logic [TIME_W-1:0] r_ticks, n_ticks;
    logic [PEN_W-1:0]  r_pen;

    logic              best_found;
    logic [IDXW-1:0]   best_idx;
    t_entry            best;
    logic              free_found;
    logic [IDXW-1:0]   free_idx;

    logic              tab_we;
    logic [IDXW-1:0]   tab_idx;
    t_entry            tab_wdata;

    t_mode             m0, m1;
    t_entry            run1;
    logic [PEN_W-1:0]  sl1;
    logic              dispatch, left, fin;
    t_result           res;

    rps_best_sel #(.N(N), .IDXW(IDXW)) u_best (
        .i_valid (r_valid),
        .i_table (r_table),
        .o_found (best_found),
        .o_idx   (best_idx),
        .o_entry (best)
    );

    // lowest empty slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_idx   = IDXW'(i);
            end
        end
    end

    always_comb begin
        n_valid   = r_valid;
        n_run     = r_run;
        n_mode    = r_mode;
        n_sl      = r_sl;
        n_time    = r_time;
        n_tally   = r_tally;
        n_ticks   = r_ticks;
        tab_we    = 1'b0;
        tab_idx   = free_idx;
        tab_wdata = '{arr: r_time,
                      rem: (i_item.burst == '0) ? BURST_W'(1) : i_item.burst,
                      prio: i_item.priority_req,
                      id: i_item.task_id};
        m0        = r_mode;
        m1        = r_mode;
        run1      = r_run;
        sl1       = r_sl;
        dispatch  = 1'b0;
        left      = 1'b0;
        fin       = 1'b0;
        res       = '0;

        if (i_item.command == CMD_ARRIVE) begin
            if (free_found) begin
                tab_we            = 1'b1;
                n_valid[free_idx] = 1'b1;
            end else begin
                res.dropped = 1'b1;
            end
            res.cpu_state  = mode_code(r_mode);
            res.running_id = (r_mode == MODE_IDLE) ? '0 : r_run.id;
        end else begin
            m0 = (r_mode == MODE_SWITCH && r_sl == '0) ? MODE_RUN : r_mode;
            m1 = m0;
            if (m0 != MODE_SWITCH) begin
                if (m0 == MODE_RUN) begin
                    if (r_run.rem == '0) begin
                        fin      = 1'b1;
                        dispatch = 1'b1;
                        left     = 1'b1;
                    end else if (best_found && best.prio < r_run.prio) begin
                        dispatch = 1'b1;
                        left     = 1'b1;
                    end
                end else if (best_found) begin
                    dispatch = 1'b1;
                end
                if (dispatch) begin
                    if (best_found) begin
                        if (!fin && m0 == MODE_RUN) begin
                            // preempted task goes back to the slot it frees
                            tab_we    = 1'b1;
                            tab_idx   = best_idx;
                            tab_wdata = r_run;
                        end else begin
                            n_valid[best_idx] = 1'b0;
                        end
                        run1 = best;
                        m1   = MODE_RUN;
                        if (left) begin
                            n_tally = sat_add(r_tally, TIME_W'(1));
                            n_ticks = sat_add(r_ticks, TIME_W'(r_pen));
                            if (r_pen != '0) begin
                                m1  = MODE_SWITCH;
                                sl1 = r_pen;
                            end
                        end
                    end else begin
                        run1 = '0;
                        m1   = MODE_IDLE;
                    end
                end
            end

            n_mode = m1;
            n_run  = run1;
            n_sl   = sl1;
            if (m1 == MODE_SWITCH) begin
                n_sl = sl1 - PEN_W'(1);
                if (n_sl == '0) begin
                    n_mode = MODE_RUN;
                end
            end else if (m1 == MODE_RUN) begin
                if (run1.rem != '0) begin
                    n_run.rem = run1.rem - BURST_W'(1);
                end
            end
            n_time = r_time + TIME_W'(1);

            res.cpu_state  = mode_code(m1);
            res.running_id = (m1 == MODE_IDLE) ? '0 : n_run.id;
            res.finished   = fin;
            if (fin) begin
                res.finished_id = r_run.id;
                res.turnaround  = r_time - r_run.arr;
            end
        end

        res.now_time          = n_time;
        res.switch_count      = n_tally;
        res.switch_time_total = n_ticks;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (i_fire && tab_we) begin
            r_table[tab_idx] <= tab_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_run   <= '0;
            r_mode  <= MODE_IDLE;
            r_sl    <= '0;
            r_time  <= '0;
            r_tally <= '0;
            r_ticks <= '0;
        end else if (i_fire) begin
            r_valid <= n_valid;
            r_run   <= n_run;
            r_mode  <= n_mode;
            r_sl    <= n_sl;
            r_time  <= n_time;
            r_tally <= n_tally;
            r_ticks <= n_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen <= PEN_W'(1);
        end else if (i_cfg_we) begin
            r_pen <= i_cfg_wdata;
        end
    end

    a_sl_only_switching: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_SWITCH) |-> (r_sl == '0))
        else $error("switch countdown left outside switching");

    a_switch_has_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_SWITCH) |-> (r_sl != '0))
        else $error("switching with no ticks left");

    a_idle_no_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_IDLE) |-> (r_run == '0))
        else $error("idle cpu holds a task");

    a_tally_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_tally >= $past(r_tally) && r_ticks >= $past(r_ticks)))
        else $error("switch counters went backward");

    a_drop_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && res.dropped) |-> (i_item.command == CMD_ARRIVE && !free_found))
        else $error("request dropped with room in table");

endmodule

`default_nettype wire

### rtl/preemptive_priority_scheduler_top.sv
`default_nettype none

// channel  dir  handshake                   payload
// s        in   i_s_tvalid / o_s_tready     i_s_tdata, i_s_tuser (command)
// m        out  o_m_tvalid / i_m_tready     o_m_tdata
// cfg      in   i_cfg_we                    i_cfg_wdata (switch_penalty)
//
// one request per cycle sustained while i_m_tready is high; each request gives one
// result, held in the input register at acceptance, then in the result register
// throughput set by the combinational update of the ready table and best-entry tree
// i_rst_n synchronous active low: table empty, cpu idle, time and counters zero,
// switch_penalty = 1
// a stalled result holds; the input register still takes one request behind it

module preemptive_priority_scheduler_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // task_id[7:0], priority_req[15:8], burst[31:16]
    input  wire logic [rps_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // command
    input  wire logic                              i_s_tuser,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // dropped[0], cpu_state[2:1], running_id[10:3], finished[11],
    // finished_id[19:12], turnaround[51:20], now_time[83:52],
    // switch_count[115:84], switch_time_total[147:116], zero[151:148]
    output logic [rps_pkg::OUT_DATA_W-1:0]         o_m_tdata,
    input  wire logic                              i_cfg_we,
    input  wire logic [rps_pkg::PEN_W-1:0]         i_cfg_wdata
);
    import rps_pkg::*;

    localparam int IDXW = $clog2(QUEUE_DEPTH);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    fire;
    t_result res;

    assign fire       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || fire;

    rps_core #(.N(QUEUE_DEPTH), .IDXW(IDXW)) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in <= '{command: i_s_tuser,
                      task_id: i_s_tdata[7:0],
                      priority_req: i_s_tdata[15:8],
                      burst: i_s_tdata[31:16]};
        end
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - $bits(t_result)){1'b0}}, r_out};

endmodule

`default_nettype wire
